FILE: sv/ookrct_pkg.sv
`default_nettype none
package ookrct_pkg;

    localparam int CODE_BITS = 24;
    localparam int CODE_W = 24;
    localparam int UNIT_W = 16;
    localparam int REPEAT_W = 8;
    localparam int SEGMENTS = 2 + 2 * CODE_BITS;
    localparam int SEG_W = $clog2(SEGMENTS);
    localparam int BIT_IDX_W = (CODE_BITS > 1) ? $clog2(CODE_BITS) : 1;
    localparam int UNITS_W = 5;
    localparam int TICKS_W = UNITS_W + UNIT_W;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [UNITS_W-1:0] START_HIGH_UNITS = 5'd1;
    localparam logic [UNITS_W-1:0] START_LOW_UNITS = 5'd31;
    localparam logic [UNITS_W-1:0] LONG_UNITS = 5'd3;
    localparam logic [UNITS_W-1:0] SHORT_UNITS = 5'd1;

    localparam logic [CFG_IDX_W-1:0] REG_UNIT_TICKS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_REPEATS = 1'd1;

    localparam logic [UNIT_W-1:0] UNIT_TICKS_RESET = 16'd4;
    localparam logic [REPEAT_W-1:0] FRAME_REPEATS_RESET = 8'd8;

    localparam logic KIND_TICK = 1'b0;
    localparam logic KIND_SEND = 1'b1;

    typedef struct packed {
        logic              kind;
        logic [CODE_W-1:0] code;
    } item_t;

    typedef struct packed {
        logic rf_level;
        logic busy_res;
        logic all_done;
        logic rejected;
    } result_t;

    typedef struct packed {
        logic [UNIT_W-1:0]   unit_ticks;
        logic [REPEAT_W-1:0] frame_repeats;
    } cfg_t;

endpackage
`default_nettype wire

FILE: sv/ookrct_core.sv
`default_nettype none
module ookrct_core
    import ookrct_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    take,
    input  wire item_t   item,
    input  wire cfg_t    cfg,
    output result_t      res
);

    logic [CODE_BITS-1:0] held_code_reg, held_code_next;
    logic [SEG_W-1:0]     segment_reg, segment_next;
    logic [TICKS_W-1:0]   ticks_left_reg, ticks_left_next;
    logic [REPEAT_W-1:0]  repeats_left_reg, repeats_left_next;
    logic                 sending_reg, sending_next;

    logic [UNIT_W-1:0]    unit;
    logic [REPEAT_W-1:0]  frames;
    logic [SEG_W-1:0]     seg_inc;
    logic [SEG_W-1:0]     seg_off;
    logic [BIT_IDX_W-1:0] bit_pos;
    logic                 bit_one;
    logic [UNITS_W-1:0]   inc_units;
    logic [TICKS_W-1:0]   inc_ticks;
    logic [TICKS_W-1:0]   ticks_dec;

    assign unit = (cfg.unit_ticks == '0) ? UNIT_W'(1) : cfg.unit_ticks;
    assign frames = (cfg.frame_repeats == '0) ? REPEAT_W'(1) : cfg.frame_repeats;

    // units of the segment that follows the current one
    assign seg_inc = segment_reg + SEG_W'(1);
    assign seg_off = seg_inc - SEG_W'(2);
    assign bit_pos = BIT_IDX_W'(seg_off >> 1);
    assign bit_one = held_code_reg[bit_pos];

    always_comb
    begin
        if (seg_inc == SEG_W'(1))
            inc_units = START_LOW_UNITS;
        else if (seg_inc[0] == 1'b0)
            inc_units = bit_one ? LONG_UNITS : SHORT_UNITS;
        else
            inc_units = bit_one ? SHORT_UNITS : LONG_UNITS;
    end

    assign inc_ticks = TICKS_W'(inc_units) * TICKS_W'(unit);
    assign ticks_dec = (ticks_left_reg != '0) ? ticks_left_reg - TICKS_W'(1) : '0;

    always_comb
    begin
        held_code_next = held_code_reg;
        segment_next = segment_reg;
        ticks_left_next = ticks_left_reg;
        repeats_left_next = repeats_left_reg;
        sending_next = sending_reg;
        res = '0;
        if (item.kind == KIND_SEND)
        begin
            if (sending_reg)
                res.rejected = 1'b1;
            else
            begin
                held_code_next = CODE_BITS'(item.code);
                repeats_left_next = frames;
                sending_next = 1'b1;
                segment_next = '0;
                ticks_left_next = TICKS_W'(unit);
            end
        end
        else if (sending_reg)
        begin
            ticks_left_next = ticks_dec;
            if (ticks_dec == '0)
            begin
                if (32'(seg_inc) < SEGMENTS)
                begin
                    segment_next = seg_inc;
                    ticks_left_next = inc_ticks;
                end
                else if (repeats_left_reg > REPEAT_W'(1))
                begin
                    repeats_left_next = repeats_left_reg - REPEAT_W'(1);
                    segment_next = '0;
                    ticks_left_next = TICKS_W'(unit);
                end
                else
                begin
                    repeats_left_next = '0;
                    segment_next = '0;
                    sending_next = 1'b0;
                    res.all_done = 1'b1;
                end
            end
        end
        res.busy_res = sending_next;
        res.rf_level = sending_next & ~segment_next[0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_code_reg <= '0;
            segment_reg <= '0;
            ticks_left_reg <= '0;
            repeats_left_reg <= '0;
            sending_reg <= 1'b0;
        end
        else if (take)
        begin
            held_code_reg <= held_code_next;
            segment_reg <= segment_next;
            ticks_left_reg <= ticks_left_next;
            repeats_left_reg <= repeats_left_next;
            sending_reg <= sending_next;
        end
    end

endmodule
`default_nettype wire

FILE: sv/ook_remote_code_transmitter.sv
// A result is registered in the output buffer after its item transfer.
// Throughput: one item per cycle when not stalled; each item's state update is a
// single counter step and segment length multiply between the state registers.
// A two-entry output buffer keeps input transfers flowing for one stalled result.
// Reset (rst_n, asynchronous, active low): idle, registers at 4 and 8, no result.
`default_nettype none
module ook_remote_code_transmitter
    import ookrct_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  item_valid,
    output logic                       item_stall,
    input  wire item_t                 item,
    output logic                       result_valid,
    input  wire logic                  result_stall,
    output result_t                    result,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t    cfg_reg;
    result_t core_res;
    result_t out_reg;
    result_t skid_reg;
    logic    out_valid_reg;
    logic    skid_valid_reg;
    logic    take;

    assign item_stall = skid_valid_reg;
    assign take = item_valid & ~skid_valid_reg;
    assign result_valid = out_valid_reg;
    assign result = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.unit_ticks <= UNIT_TICKS_RESET;
            cfg_reg.frame_repeats <= FRAME_REPEATS_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_UNIT_TICKS:    cfg_reg.unit_ticks <= cfg_data[UNIT_W-1:0];
                REG_FRAME_REPEATS: cfg_reg.frame_repeats <= cfg_data[REPEAT_W-1:0];
                default:           cfg_reg <= cfg_reg;
            endcase
        end
    end

    ookrct_core u_core
    (
        .clk   (clk),
        .rst_n (rst_n),
        .take  (take),
        .item  (item),
        .cfg   (cfg_reg),
        .res   (core_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || !result_stall)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
                out_valid_reg <= take;
        end
        else if (take)
            skid_valid_reg <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || !result_stall)
        begin
            if (skid_valid_reg)
                out_reg <= skid_reg;
            else if (take)
                out_reg <= core_res;
        end
        else if (take)
            skid_reg <= core_res;
    end

endmodule
`default_nettype wire
